### rtl/nbg_pkg.sv
// shared types and fixed widths for the n-body gravity derivative core
// no dependencies

package nbg_pkg;

  localparam int AXES        = 3;
  // shared datapath width: exactly holds a 128 x 34 bit product
  localparam int AW          = 162;
  // dividend and quotient shift register width
  localparam int QW          = 120;
  // accumulator width with guard bits, plus one mark bit in memory
  localparam int ACCW        = 54;
  localparam int OUTW        = 48;
  localparam int CNTW        = 7;
  localparam int MUL_STEPS   = 34;
  localparam int DIV_STEPS   = 120;
  localparam int SQRT_STEPS  = 34;
  localparam int CFG_IW      = 1;

  localparam logic [CFG_IW-1:0] KAPPA_IDX = 1'b0;
  localparam logic [CFG_IW-1:0] PIN_IDX   = 1'b1;

  localparam logic [31:0] KAPPA_RESET = 32'd1099512;

  typedef struct packed {
    logic sub;
    logic use_b;
  } alu_ctl_t;

endpackage

### rtl/nbg_alu.sv
// shared wide add/subtract unit with carry out for compares
// depends on nbg_pkg

module nbg_alu (
  input  nbg_pkg::alu_ctl_t          ctl,
  input  logic [nbg_pkg::AW-1:0]     a,
  input  logic [nbg_pkg::AW-1:0]     b,
  output logic [nbg_pkg::AW-1:0]     sum,
  output logic                       cout
);
  import nbg_pkg::*;

  logic [AW-1:0] bg;
  logic [AW-1:0] bx;

  always_comb begin
    bg = ctl.use_b ? b : '0;
    bx = ctl.sub ? ~bg : bg;
    {cout, sum} = {1'b0, a} + {1'b0, bx} + (AW+1)'(ctl.sub);
  end

endmodule

### rtl/nbody_gravity_derivatives_core.sv
// load: one item per cycle while idle; after the last item the set is computed
// compute: clear, then each of the n(n-1)/2 pairs, with a longer path inside contact,
// multiply, divide and root steps all on one shared adder; then the results one at a time
// throughput: one set at a time, busy stays high from the last item to the last result
// reset: synchronous, clears the sequencer and body count, kappa 1099512, pin on
// results are strobed by done for one cycle each; the receiver cannot stall

module nbody_gravity_derivatives_core #(
  parameter int MAX_BODIES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [nbg_pkg::CFG_IW-1:0]     cfg_idx,
  input  logic [31:0]                    cfg_data,
  // input item
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             pos_x,
  input  logic signed [31:0]             pos_y,
  input  logic signed [31:0]             pos_z,
  input  logic signed [31:0]             vel_x,
  input  logic signed [31:0]             vel_y,
  input  logic signed [31:0]             vel_z,
  input  logic [31:0]                    mass,
  input  logic [31:0]                    radius,
  input  logic                           last_body,
  // result item
  output logic                           done,
  output logic [5:0]                     body_index,
  output logic signed [31:0]             dpos_x,
  output logic signed [31:0]             dpos_y,
  output logic signed [31:0]             dpos_z,
  output logic signed [47:0]             acc_x,
  output logic signed [47:0]             acc_y,
  output logic signed [47:0]             acc_z,
  output logic                           saturated,
  output logic                           last_result
);
  import nbg_pkg::*;

  localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_SQ_LOAD, S_SQ_NEXT, S_MUL, S_SQRT,
    S_RSQ_LOAD, S_RSQ_DONE, S_CMP, S_DIV, S_DEN_DONE, S_IN1, S_IN2, S_IN3,
    S_F_DONE, S_TERM_LOAD, S_FM_DONE, S_PROD_LOAD, S_PROD_DONE, S_ACC_WR, S_OUT
  } state_t;

  state_t state, ret;

  // configuration
  logic [31:0] kappa;
  logic        pin;

  // sequencer counters and indices
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   count, n;
  logic [IW-1:0]   i, j;
  logic            side;
  logic [1:0]      k;

  // shared datapath registers
  logic [AW-1:0] A, B;
  logic [QW-1:0] Q;

  // per-pair registers
  logic [31:0]  pi [AXES];
  logic [32:0]  d  [AXES];
  logic [32:0]  rsum;
  logic [31:0]  rad_i, mass_i, mass_j;
  logic [65:0]  rsqr, rsumsq;
  logic [33:0]  root;
  logic [119:0] f;
  logic [127:0] fm;
  logic         fm_ovf;
  logic [48:0]  term;
  logic         capped;

  // output registers
  logic [31:0] dpos_r [AXES];
  logic [47:0] acc_r  [AXES];

  // body stores, one bank per axis
  logic [31:0] pos_mem [AXES][MAX_BODIES];
  logic [31:0] vel_mem [AXES][MAX_BODIES];
  logic [31:0] mass_mem [MAX_BODIES];
  logic [31:0] rad_mem  [MAX_BODIES];
  logic [ACCW:0] acc_mem [AXES][MAX_BODIES];

  logic [31:0]   pos_q [AXES];
  logic [31:0]   vel_q [AXES];
  logic [31:0]   mass_q, rad_q;
  logic [ACCW:0] acc_q [AXES];

  logic          wr_in;
  logic [IW-1:0] rd_addr;
  logic [2:0]    acc_we;
  logic [IW-1:0] acc_wa;
  logic [ACCW:0] acc_wd [AXES];

  // shared unit hookup
  alu_ctl_t      alu_ctl;
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_cout;

  logic [32:0]   absd [AXES];
  logic [QW-1:0] num;
  logic          prod_cap, prod_neg;
  logic [47:0]   prod_mag;
  logic [47:0]   clamp_val [AXES];
  logic [2:0]    clamp_hit;
  logic [2:0]    marks;
  logic          pinned;

  assign busy   = (state != S_IDLE);
  assign wr_in  = start && !busy && (count < CW'(MAX_BODIES));
  assign num    = {kappa, 88'b0};

  assign dpos_x = dpos_r[0];
  assign dpos_y = dpos_r[1];
  assign dpos_z = dpos_r[2];
  assign acc_x  = acc_r[0];
  assign acc_y  = acc_r[1];
  assign acc_z  = acc_r[2];

  nbg_alu u_alu (
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  // memory read address: j while fetching the second body or updating body j
  always_comb begin
    rd_addr = i;
    if ((state == S_FETCH && cnt == CNTW'(1)) || (state == S_PROD_DONE && side)) begin
      rd_addr = j;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_in) begin
      pos_mem[0][count[IW-1:0]] <= pos_x;
      pos_mem[1][count[IW-1:0]] <= pos_y;
      pos_mem[2][count[IW-1:0]] <= pos_z;
      vel_mem[0][count[IW-1:0]] <= vel_x;
      vel_mem[1][count[IW-1:0]] <= vel_y;
      vel_mem[2][count[IW-1:0]] <= vel_z;
      mass_mem[count[IW-1:0]]   <= mass;
      rad_mem[count[IW-1:0]]    <= radius;
    end
    for (int a = 0; a < AXES; a++) begin
      pos_q[a] <= pos_mem[a][rd_addr];
      vel_q[a] <= vel_mem[a][rd_addr];
    end
    mass_q <= mass_mem[rd_addr];
    rad_q  <= rad_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (acc_we[a]) begin
        acc_mem[a][acc_wa] <= acc_wd[a];
      end
      acc_q[a] <= acc_mem[a][rd_addr];
    end
  end

  // operand selection for the shared unit, accumulator writes, output clamp
  always_comb begin
    alu_a   = A;
    alu_b   = B;
    alu_ctl = '{sub: 1'b0, use_b: 1'b1};
    unique case (state)
      S_MUL: begin
        alu_ctl.use_b = Q[0];
      end
      S_SQRT: begin
        alu_a   = {A[AW-3:0], Q[QW-1:QW-2]};
        alu_b   = AW'({root, 2'b01});
        alu_ctl = '{sub: 1'b1, use_b: 1'b1};
      end
      S_DIV: begin
        alu_a   = {A[AW-2:0], Q[QW-1]};
        alu_ctl = '{sub: 1'b1, use_b: 1'b1};
      end
      S_CMP: begin
        alu_a   = AW'(rsumsq);
        alu_b   = AW'(rsqr);
        alu_ctl = '{sub: 1'b1, use_b: 1'b1};
      end
      default: begin
      end
    endcase

    for (int a = 0; a < AXES; a++) begin
      absd[a] = d[a][32] ? (~d[a] + 33'd1) : d[a];
    end

    // term magnitude: capped when f*m or f*m*|d| overruns the 47-bit range
    prod_cap = fm_ovf || (|A[AW-1:111]);
    prod_mag = prod_cap ? 48'h8000_0000_0000 : {1'b0, A[110:64]};
    prod_neg = d[k][32] ^ side;

    acc_we = '0;
    acc_wa = i;
    for (int a = 0; a < AXES; a++) begin
      acc_wd[a] = '0;
    end
    if (state == S_CLEAR) begin
      acc_we = '1;
      acc_wa = cnt[IW-1:0];
    end else if (state == S_ACC_WR) begin
      acc_we[k] = 1'b1;
      acc_wa    = side ? j : i;
      acc_wd[k] = {acc_q[k][ACCW] | capped,
                   acc_q[k][ACCW-1:0] + {{(ACCW-49){term[48]}}, term}};
    end

    for (int a = 0; a < AXES; a++) begin
      marks[a]     = acc_q[a][ACCW];
      clamp_hit[a] = 1'b0;
      clamp_val[a] = acc_q[a][OUTW-1:0];
      if (!acc_q[a][ACCW-1] && (|acc_q[a][ACCW-2:OUTW-1])) begin
        clamp_hit[a] = 1'b1;
        clamp_val[a] = 48'h7FFF_FFFF_FFFF;
      end else if (acc_q[a][ACCW-1] && !(&acc_q[a][ACCW-2:OUTW-1])) begin
        clamp_hit[a] = 1'b1;
        clamp_val[a] = 48'h8000_0000_0000;
      end
    end
    pinned = (i == '0) && pin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      kappa       <= KAPPA_RESET;
      pin         <= 1'b1;
      count       <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx)
          KAPPA_IDX: kappa <= cfg_data;
          PIN_IDX:   pin   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            // items past the store depth are dropped, a dropped last still closes the set
            if (count < CW'(MAX_BODIES)) begin
              count <= count + CW'(1);
            end
            if (last_body) begin
              n     <= (count < CW'(MAX_BODIES)) ? count + CW'(1) : count;
              count <= '0;
              cnt   <= '0;
              state <= S_CLEAR;
            end
          end
        end

        // clear the accumulators and marks of the bodies in this set
        S_CLEAR: begin
          if (cnt == CNTW'(n) - CNTW'(1)) begin
            cnt <= '0;
            i   <= '0;
            j   <= IW'(1);
            state <= (n >= CW'(2)) ? S_FETCH : S_OUT;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end

        // read body i, then body j, and form the separation
        S_FETCH: begin
          if (cnt == CNTW'(0)) begin
            cnt <= CNTW'(1);
          end else if (cnt == CNTW'(1)) begin
            for (int a = 0; a < AXES; a++) begin
              pi[a] <= pos_q[a];
            end
            rad_i  <= rad_q;
            mass_i <= mass_q;
            cnt    <= CNTW'(2);
          end else begin
            for (int a = 0; a < AXES; a++) begin
              d[a] <= {pos_q[a][31], pos_q[a]} - {pi[a][31], pi[a]};
            end
            rsum   <= {1'b0, rad_i} + {1'b0, rad_q};
            mass_j <= mass_q;
            k      <= '0;
            A      <= '0;
            state  <= S_SQ_LOAD;
          end
        end

        // squared distance, accumulated in A over the three axes
        S_SQ_LOAD: begin
          B     <= AW'(absd[k]);
          Q     <= QW'(absd[k]);
          cnt   <= '0;
          ret   <= S_SQ_NEXT;
          state <= S_MUL;
        end

        S_SQ_NEXT: begin
          if (k == 2'd2) begin
            rsqr  <= A[65:0];
            A     <= '0;
            root  <= '0;
            Q     <= {2'b00, A[65:0], 52'b0};
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            k     <= k + 2'd1;
            state <= S_SQ_LOAD;
          end
        end

        // shift-add multiply: A += B when the multiplier bit is set
        S_MUL: begin
          A <= alu_sum;
          B <= B << 1;
          Q <= Q >> 1;
          if (cnt == CNTW'(MUL_STEPS - 1)) begin
            state <= ret;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end

        // two bits of radicand per step, one root bit out
        S_SQRT: begin
          A    <= alu_cout ? alu_sum : alu_a;
          root <= {root[32:0], alu_cout};
          Q    <= Q << 2;
          if (cnt == CNTW'(SQRT_STEPS - 1)) begin
            state <= S_RSQ_LOAD;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end

        S_RSQ_LOAD: begin
          A     <= '0;
          B     <= AW'(rsum);
          Q     <= QW'(rsum);
          cnt   <= '0;
          ret   <= S_RSQ_DONE;
          state <= S_MUL;
        end

        S_RSQ_DONE: begin
          rsumsq <= A[65:0];
          state  <= S_CMP;
        end

        // carry out set means contact: rsqr no larger than rsum squared
        S_CMP: begin
          cnt <= '0;
          if (!alu_cout) begin
            A     <= '0;
            B     <= AW'(rsqr);
            Q     <= QW'(root);
            ret   <= S_DEN_DONE;
            state <= S_MUL;
          end else if (rsum == '0) begin
            f     <= '0;
            side  <= 1'b0;
            state <= S_TERM_LOAD;
          end else begin
            A     <= '0;
            B     <= AW'(rsumsq);
            Q     <= num;
            ret   <= S_IN1;
            state <= S_DIV;
          end
        end

        // restoring division, quotient shifts into Q
        S_DIV: begin
          A <= alu_cout ? alu_sum : alu_a;
          Q <= {Q[QW-2:0], alu_cout};
          if (cnt == CNTW'(DIV_STEPS - 1)) begin
            state <= ret;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end

        S_DEN_DONE: begin
          B     <= A;
          A     <= '0;
          Q     <= num;
          cnt   <= '0;
          ret   <= S_F_DONE;
          state <= S_DIV;
        end

        // contact branch: kappa/R^2, then /R, then *r, then /R
        S_IN1: begin
          A     <= '0;
          B     <= AW'(rsum);
          cnt   <= '0;
          ret   <= S_IN2;
          state <= S_DIV;
        end

        S_IN2: begin
          A     <= '0;
          B     <= AW'(Q);
          Q     <= QW'(root);
          cnt   <= '0;
          ret   <= S_IN3;
          state <= S_MUL;
        end

        S_IN3: begin
          Q     <= A[QW-1:0];
          A     <= '0;
          B     <= AW'(rsum);
          cnt   <= '0;
          ret   <= S_F_DONE;
          state <= S_DIV;
        end

        S_F_DONE: begin
          f     <= Q;
          side  <= 1'b0;
          state <= S_TERM_LOAD;
        end

        // side 0 updates body i with m_j, side 1 updates body j with m_i
        S_TERM_LOAD: begin
          A     <= '0;
          B     <= AW'(f);
          Q     <= QW'(side ? mass_i : mass_j);
          cnt   <= '0;
          ret   <= S_FM_DONE;
          state <= S_MUL;
        end

        S_FM_DONE: begin
          fm     <= A[127:0];
          fm_ovf <= |A[AW-1:128];
          k      <= '0;
          state  <= S_PROD_LOAD;
        end

        S_PROD_LOAD: begin
          A     <= '0;
          B     <= AW'(fm);
          Q     <= QW'(absd[k]);
          cnt   <= '0;
          ret   <= S_PROD_DONE;
          state <= S_MUL;
        end

        S_PROD_DONE: begin
          term   <= prod_neg ? (~{1'b0, prod_mag} + 49'd1) : {1'b0, prod_mag};
          capped <= prod_cap;
          state  <= S_ACC_WR;
        end

        S_ACC_WR: begin
          if (k != 2'd2) begin
            k     <= k + 2'd1;
            state <= S_PROD_LOAD;
          end else if (!side) begin
            side  <= 1'b1;
            state <= S_TERM_LOAD;
          end else if ((CW'(j) + CW'(1)) < n) begin
            j     <= j + IW'(1);
            cnt   <= '0;
            state <= S_FETCH;
          end else if ((CW'(i) + CW'(2)) < n) begin
            i     <= i + IW'(1);
            j     <= i + IW'(2);
            cnt   <= '0;
            state <= S_FETCH;
          end else begin
            i     <= '0;
            cnt   <= '0;
            state <= S_OUT;
          end
        end

        // one result at a time: read, then clamp and strobe
        S_OUT: begin
          if (cnt == CNTW'(0)) begin
            cnt <= CNTW'(1);
          end else begin
            for (int a = 0; a < AXES; a++) begin
              dpos_r[a] <= pinned ? '0 : vel_q[a];
              acc_r[a]  <= pinned ? '0 : clamp_val[a];
            end
            saturated   <= !pinned && ((|clamp_hit) || (|marks));
            body_index  <= 6'(i);
            last_result <= ((CW'(i) + CW'(1)) == n);
            done        <= 1'b1;
            cnt         <= '0;
            if ((CW'(i) + CW'(1)) == n) begin
              state <= S_IDLE;
            end else begin
              i <= i + IW'(1);
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/nbg_checker.sv
// port-level checks on the n-body gravity derivative core, bound to the top level
// depends on nbody_gravity_derivatives_core

module nbg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic last_body,
  input logic last_result
);

  // a result only comes out of a running compute
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running compute");

  // results are spaced, never two strobes in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // the final result releases the block unless a new set closes at once
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    done && last_result && !(start && last_body) |=> !busy)
    else $error("still busy after final result");

  // an item that does not close the set leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_body |=> !busy)
    else $error("busy after loading a non-final item");

  // more results follow while the set is not finished
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    done && !last_result |-> busy)
    else $error("idle before the final result");

endmodule

bind nbody_gravity_derivatives_core nbg_checker u_nbg_checker (.*);
